// ===== hdl/srt_pkg.sv =====
// Shared constants, tanh breakpoint table and types for the tanh p-y soil reaction block.
package srt_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int TANH_SEGMENTS = 64;
  localparam int DATA_W        = 32;
  localparam int INV_W         = 31;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_RESISTANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESISTANCE_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_REF_DISP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_AXIS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_NEG_DEPTH = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  // table entries lie in [0, 1.0]
  localparam int TAB_W      = FRAC_BITS + 1;
  localparam int SEG_IDX_W  = $clog2(TANH_SEGMENTS);
  localparam int ROM_IDX_W  = $clog2(TANH_SEGMENTS + 1);
  // tanh argument below saturation: m < 4.0
  localparam int ARG_W      = FRAC_BITS + 2;
  localparam int POS_W      = ARG_W + $clog2(TANH_SEGMENTS + 1);

  localparam logic [TAB_W-1:0] TANH_ONE = TAB_W'(1) << FRAC_BITS;
  localparam logic [63:0]      Q60_ONE  = 64'd1 << 60;

  typedef logic [TAB_W-1:0] tanh_rom_t [TANH_SEGMENTS+1];

  typedef struct packed {
    logic lookup;
    logic interp;
  } srt_adv_t;

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, mid;
    ah  = a >> 32;
    al  = a & 64'hFFFF_FFFF;
    bh  = b >> 32;
    bl  = b & 64'hFFFF_FFFF;
    mid = ah * bl + al * bh + ((al * bl) >> 32);
    return ((ah * bh) << 4) + (mid >> 28);
  endfunction

  // unsigned quotient by shift and subtract; divisor below 2^63
  function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(4k/N) = (1 - e^(-8k/N)) / (1 + e^(-8k/N)), exp by series and four squarings
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t   rom;
    logic [63:0] t, term, e, num, den, q;
    for (int k = 0; k <= TANH_SEGMENTS; k++) begin
      t    = ((64'(k) << 52) / 64'(TANH_SEGMENTS)) << 7;
      term = Q60_ONE;
      e    = Q60_ONE;
      for (int n = 1; n <= 21; n++) begin
        term = div_u64(mul_q60(term, t), 64'(n));
        if (n % 2 == 1) begin
          e = e - term;
        end else begin
          e = e + term;
        end
      end
      for (int j = 0; j < 4; j++) begin
        e = mul_q60(e, e);
      end
      num    = (Q60_ONE - e) >> 20;
      den    = (Q60_ONE + e) >> 20;
      q      = div_u64((num << FRAC_BITS) + (den >> 1), den);
      rom[k] = q[TAB_W-1:0];
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

// ===== hdl/srt_point_if.sv =====
// Point channel: coordinates and lateral displacement with valid/ready.
interface srt_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic signed [31:0] lateral_disp;

  modport source (output valid, coord_x, coord_y, coord_z, lateral_disp, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, lateral_disp, output ready);
endinterface

// ===== hdl/srt_reaction_if.sv =====
// Reaction channel: soil reaction force and error flag with valid/ready.
interface srt_reaction_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] reaction_force;
  logic               negative_resistance;

  modport source (output valid, reaction_force, negative_resistance, input ready);
  modport sink   (input valid, reaction_force, negative_resistance, output ready);
endinterface

// ===== hdl/srt_tanh.sv =====
// Two-stage tanh evaluation: table lookup with slope product, then interpolation.
module srt_tanh
  import srt_pkg::*;
(
  input  logic                 clk,
  input  srt_adv_t             adv,
  input  logic                 sat,
  input  logic [SEG_IDX_W-1:0] idx,
  input  logic [FRAC_BITS-1:0] frac,
  output logic [TAB_W-1:0]     t
);

  localparam int D_W  = TAB_W + 1;
  localparam int DP_W = D_W + FRAC_BITS + 1;

  logic [TAB_W-1:0]       tab_lo;
  logic [TAB_W-1:0]       tab_hi;
  logic signed [D_W-1:0]  slope;
  logic [TAB_W-1:0]       lo;
  logic signed [DP_W-1:0] dprod;
  logic                   sat_l;
  logic signed [DP_W-1:0] corr;
  logic signed [DP_W-1:0] sum;

  always_comb begin
    tab_lo = TANH_ROM[ROM_IDX_W'(idx)];
    tab_hi = TANH_ROM[ROM_IDX_W'(idx) + ROM_IDX_W'(1)];
    slope  = signed'({1'b0, tab_hi}) - signed'({1'b0, tab_lo});
  end

  always_ff @(posedge clk) begin
    if (adv.lookup) begin
      lo    <= tab_lo;
      dprod <= DP_W'(slope * signed'({1'b0, frac}));
      sat_l <= sat;
    end
  end

  always_comb begin
    corr = dprod >>> FRAC_BITS;
    sum  = signed'(DP_W'({1'b0, lo})) + corr;
  end

  always_ff @(posedge clk) begin
    if (adv.interp) begin
      t <= sat_l ? TANH_ONE : sum[TAB_W-1:0];
    end
  end

endmodule

// ===== hdl/soil_reaction_tanh_law.sv =====
// Pipeline: 7 register stages lie between a point transfer and its reaction being offered.
// Throughput: one point per cycle while reaction.ready is high; a full stage holds while the next cannot accept.
// Stages: depth, two multipliers, resistance/argument, table lookup,
// interpolation, force multiply, output register.
// Reset (synchronous, active high) empties the pipeline and loads register defaults.
module soil_reaction_tanh_law
  import srt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  srt_point_if.sink            point,
  srt_reaction_if.source       reaction
);

  localparam int RP_W = 2 * DATA_W;
  localparam int MP_W = DATA_W + INV_W;
  localparam int SUM_W = RP_W - FRAC_BITS + 1;
  localparam int FP_W = (DATA_W - 1) + TAB_W;

  logic signed [DATA_W-1:0] base_resistance;
  logic signed [DATA_W-1:0] resistance_rate;
  logic [INV_W-1:0]         inverse_reference_disp;
  logic [1:0]               depth_axis;
  logic signed [DATA_W-1:0] depth_offset;
  logic                     clamp_negative_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_resistance        <= '0;
      resistance_rate        <= '0;
      inverse_reference_disp <= INV_W'(1) << FRAC_BITS;
      depth_axis             <= 2'd2;
      depth_offset           <= '0;
      clamp_negative_depth   <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE_RESISTANCE: base_resistance        <= cfg_data;
        REG_RESISTANCE_RATE: resistance_rate        <= cfg_data;
        REG_INV_REF_DISP:    inverse_reference_disp <= cfg_data[INV_W-1:0];
        REG_DEPTH_AXIS:      depth_axis             <= cfg_data[1:0];
        REG_DEPTH_OFFSET:    depth_offset           <= cfg_data;
        REG_CLAMP_NEG_DEPTH: clamp_negative_depth   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // valid bits and stage advance
  logic [7:1] v;
  logic [8:1] rdy;

  always_comb begin
    rdy[8] = reaction.ready;
    for (int k = 7; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign point.ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= point.valid;
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: depth and displacement magnitude
  logic signed [DATA_W-1:0] coord;
  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W-1:0] depth_sat;
  logic signed [DATA_W-1:0] depth_c;
  logic signed [DATA_W-1:0] depth;
  logic [DATA_W-1:0]        mag;
  logic                     neg1;

  always_comb begin
    unique case (depth_axis)
      AXIS_X:  coord = point.coord_x;
      AXIS_Y:  coord = point.coord_y;
      default: coord = point.coord_z;
    endcase
    diff = signed'({coord[DATA_W-1], coord}) - signed'({depth_offset[DATA_W-1], depth_offset});
    if (diff[DATA_W] != diff[DATA_W-1]) begin
      depth_sat = {diff[DATA_W], {(DATA_W-1){~diff[DATA_W]}}};
    end else begin
      depth_sat = diff[DATA_W-1:0];
    end
    depth_c = (clamp_negative_depth && depth_sat[DATA_W-1]) ? '0 : depth_sat;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      depth <= depth_c;
      mag   <= point.lateral_disp[DATA_W-1] ? DATA_W'(-point.lateral_disp)
                                            : DATA_W'(point.lateral_disp);
      neg1  <= point.lateral_disp[DATA_W-1];
    end
  end

  // stage 2: depth term and tanh argument products
  logic signed [RP_W-1:0] rate_prod;
  logic [MP_W-1:0]        arg_prod;
  logic                   neg2;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      rate_prod <= resistance_rate * depth;
      arg_prod  <= MP_W'(mag) * MP_W'(inverse_reference_disp);
      neg2      <= neg1;
    end
  end

  // stage 3: saturated resistance, table position
  logic signed [SUM_W-1:0]  pult_sum;
  logic signed [DATA_W-1:0] pult_c;
  logic [MP_W-FRAC_BITS-1:0] m;
  logic [POS_W-1:0]          pos;
  logic signed [DATA_W-1:0] pult3;
  logic                     perr3;
  logic                     sat3;
  logic [SEG_IDX_W-1:0]     idx3;
  logic [FRAC_BITS-1:0]     frac3;
  logic                     neg3;

  always_comb begin
    pult_sum = signed'(SUM_W'(base_resistance)) + SUM_W'(rate_prod >>> FRAC_BITS);
    if (pult_sum[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){pult_sum[SUM_W-1]}}) begin
      pult_c = {pult_sum[SUM_W-1], {(DATA_W-1){~pult_sum[SUM_W-1]}}};
    end else begin
      pult_c = pult_sum[DATA_W-1:0];
    end
    m   = arg_prod[MP_W-1:FRAC_BITS];
    pos = (POS_W'(m[ARG_W-1:0]) * POS_W'(TANH_SEGMENTS)) >> 2;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      pult3 <= pult_c;
      perr3 <= pult_c[DATA_W-1];
      sat3  <= (m >> ARG_W) != '0;
      idx3  <= pos[FRAC_BITS +: SEG_IDX_W];
      frac3 <= pos[FRAC_BITS-1:0];
      neg3  <= neg2;
    end
  end

  // stages 4 and 5: tanh, resistance rides alongside
  srt_adv_t         adv;
  logic [TAB_W-1:0] t5;
  logic [DATA_W-2:0] pult4, pult5;
  logic              perr4, perr5, neg4, neg5;

  assign adv.lookup = rdy[4];
  assign adv.interp = rdy[5];

  srt_tanh u_tanh (
    .clk  (clk),
    .adv  (adv),
    .sat  (sat3),
    .idx  (idx3),
    .frac (frac3),
    .t    (t5)
  );

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      pult4 <= pult3[DATA_W-2:0];
      perr4 <= perr3;
      neg4  <= neg3;
    end
    if (rdy[5]) begin
      pult5 <= pult4;
      perr5 <= perr4;
      neg5  <= neg4;
    end
  end

  // stage 6: force magnitude product
  logic [FP_W-1:0] force_prod;
  logic            perr6, neg6;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      force_prod <= FP_W'(pult5) * FP_W'(t5);
      perr6      <= perr5;
      neg6       <= neg5;
    end
  end

  // stage 7: sign and error, output register
  logic [DATA_W-1:0] fm;

  assign fm = force_prod[FRAC_BITS +: DATA_W];

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      if (perr6) begin
        reaction.reaction_force <= '0;
      end else if (neg6) begin
        reaction.reaction_force <= -signed'(fm);
      end else begin
        reaction.reaction_force <= signed'(fm);
      end
      reaction.negative_resistance <= perr6;
    end
  end

  assign reaction.valid = v[7];

endmodule

// ===== hdl/srt_checker.sv =====
// Port-level checks for the tanh p-y soil reaction block, bound to the top level.
module srt_checker (
  input logic        clk,
  input logic        rst,
  input logic        point_valid,
  input logic        point_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] reaction_force,
  input logic        negative_resistance
);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(reaction_force)
      && $stable(negative_resistance))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && negative_resistance |-> reaction_force == 32'd0)
    else $error("non-zero force on negative resistance");

  // magnitude never exceeds the positive range
  a_no_min: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> reaction_force != 32'h8000_0000)
    else $error("force magnitude overflow");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result offered straight after reset");

  // an empty output stage never refuses a transfer
  a_ready: assert property (@(posedge clk) disable iff (rst)
    result_ready && !result_valid && !$past(point_valid) |-> point_ready)
    else $error("input stalled with drained output");

endmodule

bind soil_reaction_tanh_law srt_checker u_srt_checker (
  .clk                 (clk),
  .rst                 (rst),
  .point_valid         (point.valid),
  .point_ready         (point.ready),
  .result_valid        (reaction.valid),
  .result_ready        (reaction.ready),
  .reaction_force      (reaction.reaction_force),
  .negative_resistance (reaction.negative_resistance)
);

// ===== tb/soil_reaction_tanh_law_tb.sv =====
// Self-checking testbench for the tanh p-y soil reaction block: directed table, then random phases.
module soil_reaction_tanh_law_tb
  import srt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B  = 3'd7;
  localparam logic [1:0]           AXIS_Z       = 2'd2;
  localparam logic [1:0]           AXIS_Z_ALIAS = 2'd3;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam longint      Q_HI  = 64'sd2147483647;
  localparam longint      Q_LO  = -64'sd2147483648;

  localparam int TANH_SPAN      = 4;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 73;
  localparam int LATENCY        = 7;
  localparam int WATCHDOG_LIMIT = 500;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] d;
  } point_t;

  typedef struct packed {
    logic signed [31:0] reaction_force;
    logic               negative_resistance;
  } reaction_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_POINT, ROW_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [DATA_W-1:0]      value;
    point_t                 pt;
    reaction_t              known;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  srt_point_if    pt_ch ();
  srt_reaction_if rc_ch ();

  soil_reaction_tanh_law dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point     (pt_ch),
    .reaction  (rc_ch)
  );

  // predictor's copy of the registers
  logic signed [31:0] cfg_base;
  logic signed [31:0] cfg_rate;
  logic [INV_W-1:0]   cfg_inv;
  logic [1:0]         cfg_axis;
  logic signed [31:0] cfg_offset;
  logic               cfg_clamp;
  longint             tanh_tab [TANH_SEGMENTS+1];

  reaction_t pending_reactions [$];
  row_t      directed_rows [$];

  bit     no_idle;
  int     stall_left;
  int     quiet_cycles;
  int     failures;
  int     points_sent;
  int     directed_points;
  int     reactions_seen;
  int     negatives_seen;
  int     saturated_args;
  int     writes_done;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clip_q(input longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [DATA_W-1:0] value);
    case (idx)
      REG_BASE_RESISTANCE: cfg_base   = value;
      REG_RESISTANCE_RATE: cfg_rate   = value;
      REG_INV_REF_DISP:    cfg_inv    = value[INV_W-1:0];
      REG_DEPTH_AXIS:      cfg_axis   = value[1:0];
      REG_DEPTH_OFFSET:    cfg_offset = value;
      REG_CLAMP_NEG_DEPTH: cfg_clamp  = value[0];
      default: ;
    endcase
  endfunction

  function automatic reaction_t soil_reaction_of(input point_t p);
    logic signed [31:0] coord;
    longint             depth, pult, mag, arg, pos, seg, frac, slope, th, mag_force;
    reaction_t          r;
    case (cfg_axis)
      AXIS_X:  coord = p.x;
      AXIS_Y:  coord = p.y;
      default: coord = p.z;
    endcase
    depth = clip_q(longint'(coord) - longint'(cfg_offset));
    if (cfg_clamp && depth < 0) depth = 0;
    pult = clip_q(longint'(cfg_base) + ((longint'(cfg_rate) * depth) >>> FRAC_BITS));
    if (pult < 0) begin
      r.reaction_force      = '0;
      r.negative_resistance = 1'b1;
      return r;
    end
    mag = (p.d < 0) ? -longint'(p.d) : longint'(p.d);
    arg = (mag * longint'(cfg_inv)) >>> FRAC_BITS;
    if (arg >= (longint'(TANH_SPAN) << FRAC_BITS)) begin
      th = longint'(1) << FRAC_BITS;
      saturated_args++;
    end else begin
      pos   = arg * TANH_SEGMENTS / TANH_SPAN;
      seg   = pos >>> FRAC_BITS;
      frac  = pos & ((longint'(1) << FRAC_BITS) - 1);
      slope = tanh_tab[int'(seg) + 1] - tanh_tab[int'(seg)];
      th    = tanh_tab[int'(seg)] + ((slope * frac) >>> FRAC_BITS);
    end
    mag_force             = (pult * th) >>> FRAC_BITS;
    r.reaction_force      = 32'((p.d < 0) ? -mag_force : mag_force);
    r.negative_resistance = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] draw_q(input int top_bit);
    logic [31:0] v;
    v = $urandom & 32'((64'd1 << $urandom_range(0, top_bit)) - 1);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 2))
      0:       return $urandom;
      1:       return cfg_offset + draw_q(24);
      default: return draw_q(32);
    endcase
  endfunction

  function automatic point_t random_point();
    point_t p;
    longint want_arg;
    p.x = pick_coord();
    p.y = pick_coord();
    p.z = pick_coord();
    // with a nonzero cfg_inv, half the points aim the tanh argument at the table range and just past it
    if ($urandom_range(0, 1) && cfg_inv != 0) begin
      want_arg = $urandom_range(0, 5 << FRAC_BITS);
      want_arg = (want_arg << FRAC_BITS) / longint'(cfg_inv);
      if (want_arg > Q_HI) want_arg = Q_HI;
      p.d = 32'(want_arg);
      if ($urandom_range(0, 1)) p.d = -p.d;
    end else begin
      p.d = $urandom_range(0, 1) ? $urandom : draw_q(32);
    end
    return p;
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DATA_W-1:0] value);
    row_t r;
    r.kind  = ROW_WRITE;
    r.index = idx;
    r.value = value;
    r.pt    = '0;
    r.known = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_point(input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] z, input logic [31:0] d);
    row_t r;
    r.kind  = ROW_POINT;
    r.index = '0;
    r.value = '0;
    r.pt    = {x, y, z, d};
    r.known = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_known(input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] z, input logic [31:0] d,
                                    input logic [31:0] rf, input logic neg);
    row_t r;
    r.kind  = ROW_KNOWN;
    r.index = '0;
    r.value = '0;
    r.pt    = {x, y, z, d};
    r.known = {rf, neg};
    directed_rows.push_back(r);
  endfunction

  task automatic send_point(input point_t p, input bit known, input reaction_t known_r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      pt_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pt_ch.valid        <= 1'b1;
    pt_ch.coord_x      <= p.x;
    pt_ch.coord_y      <= p.y;
    pt_ch.coord_z      <= p.z;
    pt_ch.lateral_disp <= p.d;
    do @(posedge clk); while (!pt_ch.ready);
    pending_reactions.push_back(known ? known_r : soil_reaction_of(p));
    points_sent++;
  endtask

  // registers change only with the pipeline drained
  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] value);
    @(negedge clk);
    pt_ch.valid <= 1'b0;
    while (pending_reactions.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    apply_setting(idx, value);
    writes_done++;
  endtask

  // receiving side
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rc_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      rc_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_reactions
    reaction_t want;
    if (!rst && rc_ch.valid && rc_ch.ready) begin
      stall_left = no_idle ? 0 : $urandom_range(0, 9);
      reactions_seen++;
      if (rc_ch.negative_resistance === 1'b1) negatives_seen++;
      if (pending_reactions.size() == 0) begin
        $error("reaction transfer with none outstanding: force %0d, flag %0b",
               rc_ch.reaction_force, rc_ch.negative_resistance);
        failures++;
      end else begin
        want = pending_reactions.pop_front();
        if (rc_ch.reaction_force !== want.reaction_force) begin
          $error("reaction_force: expected %0d, got %0d",
                 want.reaction_force, rc_ch.reaction_force);
          failures++;
        end
        if (rc_ch.negative_resistance !== want.negative_resistance) begin
          $error("negative_resistance: expected %0b, got %0b",
                 want.negative_resistance, rc_ch.negative_resistance);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pt_ch.valid && pt_ch.ready) || (rc_ch.valid && rc_ch.ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d reactions outstanding",
               quiet_cycles, pending_reactions.size());
      $display("soil_reaction_tanh_law_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [63:0]  arg, term, ex, num, den;
    logic [127:0] wide;
    logic [31:0]  base, rate, inv, offs;
    logic [1:0]   axis;
    logic         clamp;
    int           k, n, ph;

    clk                = 1'b0;
    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    pt_ch.valid        = 1'b0;
    pt_ch.coord_x      = '0;
    pt_ch.coord_y      = '0;
    pt_ch.coord_z      = '0;
    pt_ch.lateral_disp = '0;
    rc_ch.ready        = 1'b0;
    no_idle            = 1'b0;
    stall_left         = 0;
    quiet_cycles       = 0;
    failures           = 0;

    cfg_base   = '0;
    cfg_rate   = '0;
    cfg_inv    = INV_W'(32'h0001_0000);
    cfg_axis   = AXIS_Z;
    cfg_offset = '0;
    cfg_clamp  = 1'b1;

    // tanh(4k/N) via e^(-8k/N): Q60 series on k/2N, then four squarings
    for (k = 0; k <= TANH_SEGMENTS; k++) begin
      arg  = ((64'(k) << 52) / 64'(TANH_SEGMENTS)) << 7;
      term = Q60_ONE;
      ex   = Q60_ONE;
      for (n = 1; n <= 21; n++) begin
        wide = {64'd0, term} * {64'd0, arg};
        term = wide[123:60] / 64'(n);
        if (n % 2 == 1) begin
          ex = ex - term;
        end else begin
          ex = ex + term;
        end
      end
      repeat (4) begin
        wide = {64'd0, ex} * {64'd0, ex};
        ex   = wide[123:60];
      end
      num         = (Q60_ONE - ex) >> 20;
      den         = (Q60_ONE + ex) >> 20;
      tanh_tab[k] = longint'(((num << FRAC_BITS) + (den >> 1)) / den);
    end

    // reset values: zero resistance gives zero force
    add_known(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    add_known(Q_MAX, Q_MIN, Q_MAX, Q_MAX, 32'd0, 1'b0);
    add_write(REG_BASE_RESISTANCE, Q_MAX);
    add_known(32'd0, 32'd0, 32'd0, Q_MAX, Q_MAX, 1'b0);
    add_known(32'd0, 32'd0, 32'd0, Q_MIN, 32'h8000_0001, 1'b0);
    add_known(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    add_known(32'd0, 32'd0, 32'd0, 32'h0004_0000, Q_MAX, 1'b0);
    add_point(32'd0, 32'd0, 32'd0, 32'h0003_FFFF);
    add_point(32'd0, 32'd0, 32'd0, Q_ONE);
    add_write(REG_BASE_RESISTANCE, Q_MIN);
    add_known(32'd1, 32'd2, 32'd3, 32'd4, 32'd0, 1'b1);
    add_write(REG_BASE_RESISTANCE, Q_ONE);
    add_write(REG_RESISTANCE_RATE, Q_MAX);
    add_write(REG_DEPTH_AXIS, 32'(AXIS_X));
    add_write(REG_CLAMP_NEG_DEPTH, 32'd1);
    add_known(32'hFFFB_0000, 32'd0, 32'd0, Q_MAX, Q_ONE, 1'b0);
    add_known(Q_MAX, 32'd0, 32'd0, Q_MAX, Q_MAX, 1'b0);
    add_write(REG_CLAMP_NEG_DEPTH, 32'd0);
    add_known(32'hFFFB_0000, 32'd0, 32'd0, Q_MAX, 32'd0, 1'b1);
    add_known(Q_MIN, 32'd0, 32'd0, Q_MAX, 32'd0, 1'b1);
    add_write(REG_DEPTH_AXIS, 32'(AXIS_Y));
    add_write(REG_DEPTH_OFFSET, Q_MAX);
    add_known(Q_MAX, Q_MIN, Q_MAX, Q_MAX, 32'd0, 1'b1);
    // selector value three picks z
    add_write(REG_DEPTH_AXIS, 32'(AXIS_Z_ALIAS));
    add_known(Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_ONE, 1'b0);
    // top bit is outside the register, so this loads zero
    add_write(REG_INV_REF_DISP, Q_MIN);
    add_write(REG_SPARE_A, 32'hFFFF_FFFF);
    add_write(REG_SPARE_B, 32'hFFFF_FFFF);
    add_known(Q_MIN, Q_MIN, Q_MAX, Q_MAX, 32'd0, 1'b0);
    add_write(REG_INV_REF_DISP, Q_MAX);
    add_point(Q_MIN, Q_MIN, Q_MAX, 32'd1);
    add_point(Q_MIN, Q_MIN, Q_MAX, 32'hFFFF_FFFF);
    add_write(REG_INV_REF_DISP, 32'd1);
    add_point(Q_MIN, Q_MIN, Q_MAX, Q_MAX);
    add_point(Q_MIN, Q_MIN, Q_MAX, Q_MIN);
    add_write(REG_INV_REF_DISP, Q_ONE);
    add_write(REG_BASE_RESISTANCE, Q_MAX);
    add_write(REG_RESISTANCE_RATE, Q_MIN);
    add_write(REG_CLAMP_NEG_DEPTH, 32'd1);
    add_write(REG_DEPTH_AXIS, 32'(AXIS_Z));
    add_write(REG_DEPTH_OFFSET, 32'd0);
    add_known(32'd0, 32'd0, Q_MAX, Q_ONE, 32'd0, 1'b1);
    add_known(32'd0, 32'd0, Q_MIN, Q_MIN, 32'h8000_0001, 1'b0);
    add_point(32'd0, 32'd0, 32'd0, 32'h0000_8000);
    add_point(32'd0, 32'd0, 32'd0, 32'h0002_8000);
    add_point(32'd0, 32'd0, 32'd0, 32'hFFFC_4000);

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_WRITE: write_setting(directed_rows[i].index, directed_rows[i].value);
        ROW_POINT: send_point(directed_rows[i].pt, 1'b0, '0);
        default:   send_point(directed_rows[i].pt, 1'b1, directed_rows[i].known);
      endcase
    end
    directed_points = points_sent;

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          base  = Q_MAX;
          rate  = Q_MAX;
          inv   = Q_MAX;
          axis  = AXIS_Z_ALIAS;
          offs  = Q_MAX;
          clamp = 1'b0;
        end
        1: begin
          base  = Q_MIN;
          rate  = Q_MIN;
          inv   = 32'd1;
          axis  = AXIS_X;
          offs  = Q_MIN;
          clamp = 1'b1;
        end
        default: begin
          base = draw_q(30);
          if (base[31] && $urandom_range(0, 3) != 0) base = -base;
          if ($urandom_range(0, 7) == 0) base = $urandom;
          rate  = ($urandom_range(0, 7) == 0) ? $urandom : draw_q(24);
          inv   = ($urandom_range(0, 7) == 0) ? $urandom
                  : (32'd1 << $urandom_range(8, 22)) ^ $urandom_range(0, 4095);
          axis  = 2'($urandom_range(0, 3));
          offs  = ($urandom_range(0, 7) == 0) ? $urandom : draw_q(26);
          clamp = 1'($urandom_range(0, 1));
        end
      endcase
      write_setting(REG_BASE_RESISTANCE, base);
      write_setting(REG_RESISTANCE_RATE, rate);
      write_setting(REG_INV_REF_DISP, inv);
      write_setting(REG_DEPTH_AXIS, {$urandom_range(0, 1) ? $urandom : 32'd0} & ~32'd3 | axis);
      write_setting(REG_DEPTH_OFFSET, offs);
      write_setting(REG_CLAMP_NEG_DEPTH, {31'($urandom), clamp});
      no_idle = (ph % 4 == 2);
      repeat (PHASE_ITEMS) send_point(random_point(), 1'b0, '0);
    end
    no_idle = 1'b0;

    @(negedge clk);
    pt_ch.valid <= 1'b0;
    while (pending_reactions.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);

    $display("Covered %0d points (%0d directed) across %0d register writes and %0d phases.",
             points_sent, directed_points, writes_done, PHASES);
    $display("%0d reactions checked: %0d negative resistance, %0d with tanh saturated.",
             reactions_seen, negatives_seen, saturated_args);
    if (failures == 0) begin
      $display("soil_reaction_tanh_law_tb OK");
    end else begin
      $display("soil_reaction_tanh_law_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== soil_reaction_tanh_law.f =====
hdl/srt_pkg.sv
hdl/srt_point_if.sv
hdl/srt_reaction_if.sv
hdl/srt_tanh.sv
hdl/soil_reaction_tanh_law.sv
hdl/srt_checker.sv
tb/soil_reaction_tanh_law_tb.sv
